>>> design/polynomial_kernel_value_macros.svh
// Assertion macros shared by the polynomial kernel value modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef POLYNOMIAL_KERNEL_VALUE_MACROS_SVH
`define POLYNOMIAL_KERNEL_VALUE_MACROS_SVH

// Same-cycle implication.
`define PKV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PKV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pkv_pkg.sv
// Package for the polynomial kernel value block: states, datapath commands,
// status codes and fixed limits. No dependencies.
`timescale 1ns / 1ps

package pkv_pkg;

  localparam logic [10:0] MAX_DIM    = 11'd1024;
  localparam logic [3:0]  MAX_DEGREE = 4'd8;

  localparam logic [1:0] CFG_OFFSET = 2'd0;
  localparam logic [1:0] CFG_DEGREE = 2'd1;
  localparam logic [1:0] CFG_NORM   = 2'd2;
  localparam logic [1:0] CFG_LENGTH = 2'd3;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_SAT = 2'd1;
  localparam logic [1:0] STATUS_BAD = 2'd2;

  localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  localparam logic [6:0] LAST_BIT_STEP = 7'd63;
  localparam logic [2:0] LAST_MUL_STEP = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACC, ST_PREP, ST_MUL_SQ, ST_SQRT_INIT, ST_SQRT, ST_SQRT_END,
    ST_DIV, ST_DIV_END, ST_POW_INIT, ST_MUL_POW, ST_POW_STEP, ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_ACCUM, OP_PREP, OP_MUL_STEP, OP_SQRT_INIT,
    OP_SQRT_STEP, OP_SQRT_END, OP_DIV_STEP, OP_DIV_END, OP_POW_INIT,
    OP_POW_STEP, OP_LOAD
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] mstep;
  } cmd_t;

  typedef struct packed {
    logic       last;
    logic       diag_norm;
    logic       plain;
    logic       bad;
    logic [3:0] deg;
    logic       out_busy;
  } stat_t;

endpackage

>>> design/polynomial_kernel_value.sv
// Polynomial kernel value, top level. Each input transfer is captured, then accumulated.
// A vector end adds the kernel evaluation: plain mode runs the bit-serial divider
// (64 steps), normalized mode also the bit-serial square root (64 steps), and both
// use the 5-step shared multiplier for the power; diagonal normalized mode skips these.
// A waiting result holds the evaluation until the previous one is taken.
// Reset (rst_n, synchronous) clears the sums and loads register defaults.
`timescale 1ns / 1ps

module polynomial_kernel_value import pkv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // row_elem [15:0], col_elem [31:16]
  input  logic        in_tuser,   // mode [0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // kernel_value [63:0]
  output logic [1:0]  out_tuser   // status [1:0]
);

  cmd_t  cmd;
  stat_t stat;

  pkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pkv_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> design/pkv_datapath.sv
// Datapath: configuration registers, sum accumulators, shared 32x32 multiplier,
// bit-serial divider and square root, power loop and output register. Uses pkv_pkg.
`timescale 1ns / 1ps
`include "polynomial_kernel_value_macros.svh"

module pkv_datapath import pkv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic [1:0]  out_tuser
);

  logic [31:0] offset_r;
  logic [3:0]  degree_r;
  logic        norm_en_r;
  logic [10:0] vlen_r;

  logic signed [31:0] prod_x_r, prod_r_r, prod_c_r;
  logic               mode_r, last_r;
  logic signed [47:0] cross_r, rsq_r, csq_r;

  logic [3:0]  deg_r;
  logic        bad_r, sat_r, s_neg_r, x_neg_r, bneg_r, pneg_r;
  logic [63:0] mx_r;
  logic [65:0] drem_r;
  logic [63:0] dnum_r, dden_r, dq_r;
  logic [63:0] mul_a_r, mul_b_r, pp_r;
  logic [1:0]  pp_sh_r;
  logic [127:0] acc_r;
  logic [127:0] rad_r;
  logic [67:0] srem_r;
  logic [63:0] root_r;
  logic [63:0] m_r, p_r;
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [1:0]  out_user_r;

  logic signed [15:0] row_in, col_in;
  logic signed [63:0] off64, a1, a2, xs, s64, qs, base;
  logic [3:0]  deg_c;
  logic [10:0] dv_c;
  logic        plain_c, diag_norm_c, pneg_c;
  logic [65:0] div_t;
  logic [67:0] sq_t, sq_trial;
  logic [127:0] pp_shifted;
  logic [31:0] mul_pa, mul_pb;
  logic [63:0] pow_next;

  function automatic logic signed [47:0] sat_add(logic signed [47:0] a,
                                                 logic signed [31:0] p);
    logic signed [48:0] s;
    s = {a[47], a} + {{17{p[31]}}, p};
    if (s[48] != s[47]) begin
      sat_add = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      sat_add = s[47:0];
    end
  endfunction

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  assign row_in      = in_tdata[15:0];
  assign col_in      = in_tdata[31:16];
  assign off64       = {{16{offset_r[31]}}, offset_r, 16'd0};
  assign a1          = {{8{rsq_r[47]}}, rsq_r, 8'd0} + off64;
  assign a2          = {{8{csq_r[47]}}, csq_r, 8'd0} + off64;
  assign xs          = {{8{cross_r[47]}}, cross_r, 8'd0} + off64;
  assign s64         = mode_r ? {{8{rsq_r[47]}}, rsq_r, 8'd0}
                              : {{8{cross_r[47]}}, cross_r, 8'd0};
  assign deg_c       = (degree_r == 4'd0) ? 4'd1 :
                       (degree_r > MAX_DEGREE) ? MAX_DEGREE : degree_r;
  assign dv_c        = (vlen_r == 11'd0) ? 11'd1 :
                       (vlen_r > MAX_DIM) ? MAX_DIM : vlen_r;
  assign plain_c     = mode_r || !norm_en_r;
  assign diag_norm_c = mode_r && norm_en_r;
  assign qs          = s_neg_r ? -$signed(dq_r) : $signed(dq_r);
  assign base        = qs + off64;
  assign pneg_c      = bneg_r && deg_r[0] && (m_r != 64'd0);
  assign div_t       = {drem_r[64:0], dnum_r[63]};
  assign sq_t        = {srem_r[65:0], rad_r[127:126]};
  assign sq_trial    = {2'b00, root_r, 2'b01};
  assign mul_pa      = cmd.mstep[0] ? mul_a_r[63:32] : mul_a_r[31:0];
  assign mul_pb      = cmd.mstep[1] ? mul_b_r[63:32] : mul_b_r[31:0];
  assign pow_next    = acc_r[95:32];

  always_comb begin
    case (pp_sh_r)
      2'd0:    pp_shifted = {64'd0, pp_r};
      2'd1:    pp_shifted = {32'd0, pp_r, 32'd0};
      default: pp_shifted = {pp_r, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= 32'd0;
      degree_r  <= 4'd2;
      norm_en_r <= 1'b0;
      vlen_r    <= 11'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET: offset_r  <= cfg_wdata;
        CFG_DEGREE: degree_r  <= cfg_wdata[3:0];
        CFG_NORM:   norm_en_r <= cfg_wdata[0];
        CFG_LENGTH: vlen_r    <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cross_r     <= '0;
      rsq_r       <= '0;
      csq_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && (cmd.op != OP_LOAD)) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_CAPTURE: begin
          prod_x_r <= row_in * col_in;
          prod_r_r <= row_in * row_in;
          prod_c_r <= col_in * col_in;
          mode_r   <= in_tuser;
          last_r   <= in_tlast;
        end
        OP_ACCUM: begin
          cross_r <= sat_add(cross_r, prod_x_r);
          rsq_r   <= sat_add(rsq_r, prod_r_r);
          csq_r   <= sat_add(csq_r, prod_c_r);
        end
        OP_PREP: begin
          deg_r   <= deg_c;
          sat_r   <= 1'b0;
          bad_r   <= !plain_c && ((a1 == 64'sd0) || (a2 == 64'sd0) ||
                     (deg_c[0] && (a1[63] != a2[63])));
          mul_a_r <= mag64(a1);
          mul_b_r <= mag64(a2);
          mx_r    <= mag64(xs);
          x_neg_r <= xs[63];
          s_neg_r <= s64[63];
          drem_r  <= '0;
          dnum_r  <= mag64(s64);
          dden_r  <= {53'd0, dv_c};
          dq_r    <= '0;
          cross_r <= '0;
          rsq_r   <= '0;
          csq_r   <= '0;
        end
        OP_MUL_STEP: begin
          if (cmd.mstep != LAST_MUL_STEP) begin
            pp_r    <= mul_pa * mul_pb;
            pp_sh_r <= {1'b0, cmd.mstep[0]} + {1'b0, cmd.mstep[1]};
          end
          if (cmd.mstep == 3'd0) begin
            acc_r <= '0;
          end else begin
            acc_r <= acc_r + pp_shifted;
          end
        end
        OP_SQRT_INIT: begin
          rad_r  <= acc_r;
          srem_r <= '0;
          root_r <= '0;
        end
        OP_SQRT_STEP: begin
          rad_r <= {rad_r[125:0], 2'b00};
          if (sq_t >= sq_trial) begin
            srem_r <= sq_t - sq_trial;
            root_r <= {root_r[62:0], 1'b1};
          end else begin
            srem_r <= sq_t;
            root_r <= {root_r[62:0], 1'b0};
          end
        end
        OP_SQRT_END: begin
          bad_r  <= (root_r == 64'd0);
          drem_r <= {34'd0, mx_r[63:32]};
          dnum_r <= {mx_r[31:0], 32'd0};
          dden_r <= root_r;
          dq_r   <= '0;
          if ({32'd0, mx_r[63:32]} >= root_r) begin
            sat_r <= 1'b1;
          end
        end
        OP_DIV_STEP: begin
          dnum_r <= {dnum_r[62:0], 1'b0};
          if (div_t >= {2'b00, dden_r}) begin
            drem_r <= div_t - {2'b00, dden_r};
            dq_r   <= {dq_r[62:0], 1'b1};
          end else begin
            drem_r <= div_t;
            dq_r   <= {dq_r[62:0], 1'b0};
          end
        end
        OP_DIV_END: begin
          if (plain_c) begin
            m_r    <= mag64(base);
            bneg_r <= base[63];
          end else begin
            m_r    <= sat_r ? '1 : dq_r;
            bneg_r <= x_neg_r;
          end
        end
        OP_POW_INIT: begin
          pneg_r  <= pneg_c;
          p_r     <= m_r;
          mul_a_r <= m_r;
          mul_b_r <= m_r;
          if (m_r > (pneg_c ? NEG_LIMIT : POS_LIMIT)) begin
            sat_r <= 1'b1;
          end
        end
        OP_POW_STEP: begin
          p_r     <= pow_next;
          mul_a_r <= pow_next;
          if ((acc_r[127:96] != 32'd0) ||
              (pow_next > (pneg_r ? NEG_LIMIT : POS_LIMIT))) begin
            sat_r <= 1'b1;
          end
        end
        OP_LOAD: begin
          out_valid_r <= 1'b1;
          if (diag_norm_c) begin
            out_data_r <= ONE_Q32;
            out_user_r <= STATUS_OK;
          end else if (bad_r) begin
            out_data_r <= 64'd0;
            out_user_r <= STATUS_BAD;
          end else if (sat_r) begin
            out_data_r <= pneg_r ? NEG_LIMIT : POS_LIMIT;
            out_user_r <= STATUS_SAT;
          end else begin
            out_data_r <= pneg_r ? 64'(-p_r) : p_r;
            out_user_r <= STATUS_OK;
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.last      = last_r;
  assign stat.diag_norm = diag_norm_c;
  assign stat.plain     = plain_c;
  assign stat.bad       = bad_r;
  assign stat.deg       = deg_r;
  assign stat.out_busy  = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `PKV_ASSERT_NEXT(a_load_valid, cmd.op == OP_LOAD, out_tvalid, "load without valid")
  `PKV_ASSERT_IMP(a_status_code, out_tvalid, out_tuser <= STATUS_BAD, "bad status code")
  `PKV_ASSERT_IMP(a_bad_zero, out_tvalid && out_tuser == STATUS_BAD, out_tdata == '0, "nonzero value")

endmodule

>>> design/pkv_ctrl.sv
// Controller: sequences accumulation, division, square root and power steps
// and issues datapath commands. Uses pkv_pkg.
`timescale 1ns / 1ps
`include "polynomial_kernel_value_macros.svh"

module pkv_ctrl import pkv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t     state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [3:0] pow_cnt_r, pow_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      pow_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      pow_cnt_r <= pow_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    pow_cnt_nxt = pow_cnt_r;
    in_tready   = 1'b0;
    cmd.op      = OP_NONE;
    cmd.mstep   = cnt_r[2:0];
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.op    = OP_ACCUM;
        state_nxt = stat.last ? ST_PREP : ST_IDLE;
      end
      ST_PREP: begin
        cmd.op  = OP_PREP;
        cnt_nxt = '0;
        if (stat.diag_norm) begin
          state_nxt = ST_FIN;
        end else if (stat.plain) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        if (stat.bad) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.op = OP_MUL_STEP;
          if (cnt_r[2:0] == LAST_MUL_STEP) begin
            cnt_nxt   = '0;
            state_nxt = ST_SQRT_INIT;
          end else begin
            cnt_nxt = cnt_r + 7'd1;
          end
        end
      end
      ST_SQRT_INIT: begin
        cmd.op    = OP_SQRT_INIT;
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (cnt_r == LAST_BIT_STEP) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQRT_END;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      ST_SQRT_END: begin
        cmd.op    = OP_SQRT_END;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (stat.bad) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.op = OP_DIV_STEP;
          if (cnt_r == LAST_BIT_STEP) begin
            cnt_nxt   = '0;
            state_nxt = ST_DIV_END;
          end else begin
            cnt_nxt = cnt_r + 7'd1;
          end
        end
      end
      ST_DIV_END: begin
        cmd.op    = OP_DIV_END;
        state_nxt = ST_POW_INIT;
      end
      ST_POW_INIT: begin
        cmd.op      = OP_POW_INIT;
        pow_cnt_nxt = 4'd1;
        cnt_nxt     = '0;
        state_nxt   = (stat.deg == 4'd1) ? ST_FIN : ST_MUL_POW;
      end
      ST_MUL_POW: begin
        cmd.op = OP_MUL_STEP;
        if (cnt_r[2:0] == LAST_MUL_STEP) begin
          cnt_nxt   = '0;
          state_nxt = ST_POW_STEP;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      ST_POW_STEP: begin
        cmd.op      = OP_POW_STEP;
        pow_cnt_nxt = pow_cnt_r + 4'd1;
        state_nxt   = (pow_cnt_r + 4'd1 == stat.deg) ? ST_FIN : ST_MUL_POW;
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `PKV_ASSERT_IMP(a_load_free, cmd.op == OP_LOAD, !stat.out_busy, "result loaded over a waiting one")
  `PKV_ASSERT_IMP(a_capture, in_tready && in_tvalid, cmd.op == OP_CAPTURE, "transfer not captured")
  `PKV_ASSERT_NEXT(a_acc_follows, cmd.op == OP_CAPTURE, cmd.op == OP_ACCUM, "capture not accumulated")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for polynomial_kernel_value: streams vector elements,
// predicts each kernel value and status, and checks every output transfer.
// Depends on pkv_pkg and the polynomial_kernel_value RTL.
`timescale 1ns / 1ps

module tb_top;
  import pkv_pkg::*;

  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic        mode;
    logic [15:0] row;
    logic [15:0] col;
    logic        last;
  } elem_t;

  typedef struct {
    logic [63:0] value;
    logic [1:0]  status;
  } kernel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_OFFSET;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  elem_t   elem_queue[$];
  kernel_t kernel_queue[$];
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      mismatches = 0;
  int      quiet_cycles = 0;

  // Model state: running sums (Q.24) and register copies.
  longint      cross_acc, row_sq_acc, col_sq_acc;
  logic [31:0] m_offset;
  logic [3:0]  m_degree;
  logic        m_norm;
  logic [10:0] m_length;

  polynomial_kernel_value dut (.*);

  always #1 clk = ~clk;

  function automatic longint sat_add48(input longint acc, input longint p);
    longint s;
    s = acc + p;
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic logic [63:0] power_mag(input logic [63:0] m, input int deg,
                                            input logic [63:0] lim, inout bit sat);
    logic [63:0]  p;
    logic [127:0] prod;
    p = m;
    if (sat || m > lim) begin
      sat = 1'b1;
      return lim;
    end
    for (int k = 1; k < deg; k++) begin
      prod = {64'd0, p} * {64'd0, m};
      if (prod[127:96] != 0) begin
        sat = 1'b1;
        return lim;
      end
      p = prod[95:32];
      if (p > lim) begin
        sat = 1'b1;
        return lim;
      end
    end
    return p;
  endfunction

  function automatic logic [63:0] signed_power(input logic [63:0] m, input bit base_neg,
                                               input int deg, inout bit sat);
    bit          neg;
    logic [63:0] p;
    neg = base_neg && deg[0] && m != 0;
    p = power_mag(m, deg, neg ? NEG_LIMIT : POS_LIMIT, sat);
    return neg ? 64'd0 - p : p;
  endfunction

  function automatic logic [63:0] root_floor(input logic [127:0] n);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  // Sums one element pair; on a vector end returns the kernel value and clears sums.
  function automatic bit kernel_step(input elem_t e, output kernel_t k);
    longint      r, c, off, dv, s, base, a1, a2, x;
    int          deg;
    bit          sat;
    logic [63:0] g, mx, q;
    r = longint'($signed(e.row));
    c = longint'($signed(e.col));
    sat = 1'b0;
    k.value = '0;
    k.status = STATUS_OK;
    cross_acc = sat_add48(cross_acc, r * c);
    row_sq_acc = sat_add48(row_sq_acc, r * r);
    col_sq_acc = sat_add48(col_sq_acc, c * c);
    if (!e.last) return 1'b0;
    off = longint'($signed(m_offset)) * 65536;
    deg = m_degree;
    if (deg == 0) deg = 1;
    if (deg > MAX_DEGREE) deg = MAX_DEGREE;
    dv = m_length;
    if (dv == 0) dv = 1;
    if (dv > MAX_DIM) dv = MAX_DIM;
    if (e.mode && m_norm) begin
      k.value = ONE_Q32;
    end else if (e.mode || !m_norm) begin
      s = e.mode ? row_sq_acc : cross_acc;
      base = s * 256 / dv + off;
      k.value = signed_power(magnitude(base), base < 0, deg, sat);
    end else begin
      a1 = row_sq_acc * 256 + off;
      a2 = col_sq_acc * 256 + off;
      x = cross_acc * 256 + off;
      if (a1 == 0 || a2 == 0 || (deg[0] && ((a1 < 0) != (a2 < 0)))) begin
        k.status = STATUS_BAD;
      end else begin
        g = root_floor({64'd0, magnitude(a1)} * {64'd0, magnitude(a2)});
        if (g == 0) begin
          k.status = STATUS_BAD;
        end else begin
          mx = magnitude(x);
          if ((mx >> 32) >= g) begin
            sat = 1'b1;
            q = '1;
          end else begin
            q = 64'({32'd0, mx, 32'd0} / {64'd0, g});
          end
          k.value = signed_power(q, x < 0, deg, sat);
        end
      end
    end
    if (sat && k.status == STATUS_OK) k.status = STATUS_SAT;
    cross_acc = 0;
    row_sq_acc = 0;
    col_sq_acc = 0;
    return 1'b1;
  endfunction

  // Driver: predicts each accepted transfer and presents the next pending element.
  always @(posedge clk) begin
    elem_t   e;
    kernel_t k;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        e.mode = in_tuser;
        e.row = in_tdata[15:0];
        e.col = in_tdata[31:16];
        e.last = in_tlast;
        if (kernel_step(e, k)) kernel_queue.push_back(k);
      end
      if (!(in_tvalid && !in_tready)) begin
        if (elem_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          e = elem_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {e.col, e.row};
          in_tuser <= e.mode;
          in_tlast <= e.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each output transfer with the oldest predicted kernel value.
  always @(posedge clk) begin
    kernel_t k;
    out_tready <= $urandom_range(99) >= recv_stall_pct;
    if (rst_n && out_tvalid && out_tready) begin
      if (kernel_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result value=%h status=%0d", out_tdata, out_tuser);
      end else begin
        k = kernel_queue.pop_front();
        if (out_tdata !== k.value || out_tuser !== k.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                     k.value, k.status, out_tdata, out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_elem(input bit mode, input logic [15:0] row, input logic [15:0] col,
                          input bit last);
    elem_t e;
    e.mode = mode;
    e.row = row;
    e.col = col;
    e.last = last;
    elem_queue.push_back(e);
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      1, 2: return $urandom();
      3: return 16'($signed($urandom_range(8192)) - 4096);
      4: return 16'($signed($urandom_range(64)) - 32);
      default: return $urandom_range(3) == 0 ? 16'h0000 : 16'($urandom_range(255));
    endcase
  endfunction

  task automatic add_vector();
    int len;
    bit mode;
    len = $urandom_range(9) == 0 ? $urandom_range(64, 9) : $urandom_range(8, 1);
    for (int i = 0; i < len; i++) begin
      mode = $urandom_range(1);
      add_elem(mode, rand_elem(), rand_elem(), i == len - 1);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_OFFSET: m_offset = data;
      CFG_DEGREE: m_degree = data[3:0];
      CFG_NORM:   m_norm = data[0];
      default:    m_length = data[10:0];
    endcase
  endtask

  task automatic configure(input logic [31:0] off, input logic [31:0] deg,
                           input logic [31:0] norm, input logic [31:0] len);
    write_reg(CFG_OFFSET, off);
    write_reg(CFG_DEGREE, deg);
    write_reg(CFG_NORM, norm);
    write_reg(CFG_LENGTH, len);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (elem_queue.size() == 0 && !in_tvalid && kernel_queue.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_offset();
    return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
  endfunction

  initial begin
    int sent;
    cross_acc = 0;
    row_sq_acc = 0;
    col_sq_acc = 0;
    m_offset = '0;
    m_degree = 4'd2;
    m_norm = 1'b0;
    m_length = 11'd1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes, both modes, a mixed-mode vector and a zero vector.
    add_elem(1'b0, 16'h7FFF, 16'h7FFF, 1'b1);
    add_elem(1'b0, 16'h8000, 16'h8000, 1'b1);
    add_elem(1'b0, 16'h8000, 16'h7FFF, 1'b1);
    add_elem(1'b0, 16'h0000, 16'h0000, 1'b1);
    add_elem(1'b1, 16'h8000, 16'h1234, 1'b1);
    add_elem(1'b1, 16'h7FFF, 16'h8000, 1'b1);
    add_elem(1'b0, 16'h8000, 16'h8000, 1'b0);
    add_elem(1'b0, 16'h8000, 16'h8000, 1'b0);
    add_elem(1'b1, 16'h7FFF, 16'h8000, 1'b1);
    add_elem(1'b0, 16'hFFFF, 16'h0001, 1'b0);
    add_elem(1'b0, 16'h5555, 16'hAAAA, 1'b1);
    add_elem(1'b1, 16'h0001, 16'hFFFF, 1'b0);
    add_elem(1'b0, 16'h1000, 16'hF000, 1'b1);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      sent = elem_queue.size();
      while (sent < 170) begin
        add_vector();
        sent = elem_queue.size();
      end
      drain();
      case (ph)
        0: configure(32'h7FFF_FFFF, 8, 0, 1024);
        1: configure(32'h8000_0000, 7, 1, 1);
        2: configure(32'h0001_0000, 1, 1, 2047);
        3: configure(32'hFFFF_0000, 3, 1, 0);
        4: configure(32'h0000_0000, 0, 0, 1);
        5: configure(rand_offset(), 15, 1, $urandom_range(2047));
        6: configure(rand_offset(), $urandom_range(8, 1), 0, $urandom_range(16, 1));
        7: configure(32'h0000_0000, 2, 1, 4);
        8: configure($urandom(), $urandom_range(15), $urandom_range(1),
                     $urandom_range(2047));
        default: ;
      endcase
    end

    if (mismatches == 0 && kernel_queue.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
